[src/lcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  // Input width and the decimal width needed to hold any 63-bit value.
  localparam int unsigned CARD_W     = 63;
  localparam int unsigned NUM_DIGITS = 19;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;

  // Binary-to-BCD conversion: a fixed number of input bits per pipeline stage.
  localparam int unsigned STEP_BITS     = 4;
  localparam int unsigned NUM_DD_STAGES = (CARD_W + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned BIN_W         = NUM_DD_STAGES * STEP_BITS;

  // Luhn sum reduction: digits are summed in groups first, then the groups.
  localparam int unsigned GROUP_SIZE = 5;
  localparam int unsigned NUM_GROUPS = (NUM_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned GSUM_W     = 6;
  localparam int unsigned SUM_W      = 8;
  localparam int unsigned POS_W      = $clog2(NUM_DIGITS);

  // Length and prefix rules.
  localparam int unsigned MIN_DIGITS = 13;
  localparam logic [DIGIT_W-1:0] AMEX_LEAD    = 4'd3;
  localparam logic [DIGIT_W-1:0] AMEX_SEC_A   = 4'd4;
  localparam logic [DIGIT_W-1:0] AMEX_SEC_B   = 4'd7;
  localparam logic [DIGIT_W-1:0] MC_LEAD      = 4'd5;
  localparam logic [DIGIT_W-1:0] MC_SEC_LO    = 4'd1;
  localparam logic [DIGIT_W-1:0] MC_SEC_HI    = 4'd5;
  localparam logic [DIGIT_W-1:0] VISA_LEAD    = 4'd4;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
  localparam logic [DIGIT_W-1:0] DD_THRESHOLD = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_ADJUST    = 4'd3;

  typedef enum logic [1:0] {
    VERDICT_INVALID    = 2'd0,
    VERDICT_AMEX       = 2'd1,
    VERDICT_MASTERCARD = 2'd2,
    VERDICT_VISA       = 2'd3
  } verdict_e;

  // Working word of the binary-to-BCD pipeline.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dd_t;

  // Luhn contribution of one digit; doubled digits above nine fold back.
  function automatic logic [DIGIT_W-1:0] luhn_map(input logic [DIGIT_W-1:0] digit,
                                                  input logic dbl);
    logic [DIGIT_W:0] twice;
    twice = {digit, 1'b0};
    if (!dbl) begin
      return digit;
    end
    if (twice > 5'(DIGIT_MAX)) begin
      twice = twice - 5'(DIGIT_MAX);
    end
    return twice[DIGIT_W-1:0];
  endfunction

  // Remainder by ten of a sum below 256, by reciprocal multiplication.
  function automatic logic [DIGIT_W-1:0] mod10(input logic [SUM_W-1:0] s);
    logic [15:0]      prod;
    logic [SUM_W-1:0] quot;
    logic [SUM_W-1:0] rem;
    prod = 16'(s) * 16'd205;
    quot = 8'(prod[15:11]);
    rem  = s - 8'(quot * 8'd10);
    return rem[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/luhn_card_classifier_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Valid         Ready         Payload
// input     in_valid_i    in_ready_o    card_number_i (63 bits, unsigned)
// output    out_valid_o   out_ready_i   verdict_o (2 bits, unsigned)
//
// An accepted transaction reaches its verdict through 16 stages of binary-to-BCD
// conversion (four bits each) and two stages of Luhn sum and prefix decode.
// One transaction is accepted every cycle while the output side takes results.
// The whole pipeline advances together; when a result waits on the output it holds.
// Reset clears all valid bits; the data registers are not reset.
module luhn_card_classifier_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lcc_pkg::CARD_W-1:0] card_number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [1:0]                      verdict_o
);

  logic              advance;
  logic              dd_valid [lcc_pkg::NUM_DD_STAGES+1];
  lcc_pkg::dd_t      dd_data  [lcc_pkg::NUM_DD_STAGES+1];
  lcc_pkg::verdict_e verdict;

  // The pipe moves whenever its output register is empty or being drained.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // Input word: BCD digits cleared, the number padded to the conversion width.
  assign dd_valid[0] = in_valid_i;
  assign dd_data[0]  = '{bcd: '0,
                         bin: {{(lcc_pkg::BIN_W - lcc_pkg::CARD_W){1'b0}}, card_number_i}};

  // Binary-to-BCD conversion chain.
  for (genvar i = 0; i < lcc_pkg::NUM_DD_STAGES; i++) begin : g_dd
    lcc_dd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (dd_valid[i]),
      .data_i  (dd_data[i]),
      .valid_o (dd_valid[i+1]),
      .data_o  (dd_data[i+1])
    );
  end

  // Checksum, length and issuer decision; its last register drives the output.
  lcc_judge u_judge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .valid_i   (dd_valid[lcc_pkg::NUM_DD_STAGES]),
    .bcd_i     (dd_data[lcc_pkg::NUM_DD_STAGES].bcd),
    .valid_o   (out_valid_o),
    .verdict_o (verdict)
  );

  assign verdict_o = verdict;

endmodule

`default_nettype wire

[src/lcc_dd_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// One pipeline stage of the shift-and-add-3 binary-to-BCD conversion.
module lcc_dd_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire lcc_pkg::dd_t  data_i,
  output logic               valid_o,
  output lcc_pkg::dd_t       data_o
);

  logic         valid_q;
  lcc_pkg::dd_t data_d;
  lcc_pkg::dd_t data_q;

  // Shift a few binary bits into the decimal digits, correcting each digit first.
  always_comb begin
    lcc_pkg::dd_t work;
    work = data_i;
    for (int s = 0; s < lcc_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < lcc_pkg::NUM_DIGITS; d++) begin
        if (work.bcd[d*lcc_pkg::DIGIT_W +: lcc_pkg::DIGIT_W] >= lcc_pkg::DD_THRESHOLD) begin
          work.bcd[d*lcc_pkg::DIGIT_W +: lcc_pkg::DIGIT_W] =
              work.bcd[d*lcc_pkg::DIGIT_W +: lcc_pkg::DIGIT_W] + lcc_pkg::DD_ADJUST;
        end
      end
      work.bcd = {work.bcd[lcc_pkg::BCD_W-2:0], work.bin[lcc_pkg::BIN_W-1]};
      work.bin = {work.bin[lcc_pkg::BIN_W-2:0], 1'b0};
    end
    data_d = work;
  end

  // The valid bit travels with the data and holds during a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[src/lcc_judge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Luhn sum, length test and issuer prefix decode over two register stages.
module lcc_judge (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [lcc_pkg::BCD_W-1:0] bcd_i,
  output logic                           valid_o,
  output lcc_pkg::verdict_e              verdict_o
);

  logic [lcc_pkg::DIGIT_W-1:0] digit [lcc_pkg::NUM_DIGITS];
  logic [lcc_pkg::GSUM_W-1:0]  gsum_d [lcc_pkg::NUM_GROUPS];
  logic [lcc_pkg::GSUM_W-1:0]  gsum_q [lcc_pkg::NUM_GROUPS];
  logic [lcc_pkg::POS_W-1:0]   msd;
  logic [lcc_pkg::POS_W-1:0]   msd_next;
  logic [lcc_pkg::DIGIT_W-1:0] lead;
  logic [lcc_pkg::DIGIT_W-1:0] second;
  logic                        digits_ok;
  logic                        long_ok_d;
  logic                        long_ok_q;
  lcc_pkg::verdict_e           cls_d;
  lcc_pkg::verdict_e           cls_q;
  logic                        s1_valid_q;
  logic [lcc_pkg::SUM_W-1:0]   total;
  lcc_pkg::verdict_e           verdict_d;
  lcc_pkg::verdict_e           verdict_q;
  logic                        s2_valid_q;

  // Unpack the decimal digits, lowest first.
  always_comb begin
    digits_ok = 1'b1;
    for (int d = 0; d < lcc_pkg::NUM_DIGITS; d++) begin
      digit[d] = bcd_i[d*lcc_pkg::DIGIT_W +: lcc_pkg::DIGIT_W];
      if (digit[d] > lcc_pkg::DIGIT_MAX) begin
        digits_ok = 1'b0;
      end
    end
  end

  // Luhn contributions summed in small groups; odd positions are doubled.
  always_comb begin
    for (int g = 0; g < lcc_pkg::NUM_GROUPS; g++) begin
      gsum_d[g] = '0;
      for (int k = 0; k < lcc_pkg::GROUP_SIZE; k++) begin
        if (g * lcc_pkg::GROUP_SIZE + k < lcc_pkg::NUM_DIGITS) begin
          gsum_d[g] = gsum_d[g] + lcc_pkg::GSUM_W'(lcc_pkg::luhn_map(
              digit[g*lcc_pkg::GROUP_SIZE+k], ((g * lcc_pkg::GROUP_SIZE + k) % 2) == 1));
        end
      end
    end
  end

  // Position of the most significant nonzero digit gives the length and prefix.
  always_comb begin
    msd = '0;
    for (int d = 0; d < lcc_pkg::NUM_DIGITS; d++) begin
      if (digit[d] != '0) begin
        msd = lcc_pkg::POS_W'(d);
      end
    end
    msd_next  = (msd == '0) ? '0 : msd - 1'b1;
    lead      = digit[msd];
    second    = digit[msd_next];
    long_ok_d = msd >= lcc_pkg::POS_W'(lcc_pkg::MIN_DIGITS - 1);
    if (lead == lcc_pkg::AMEX_LEAD &&
        (second == lcc_pkg::AMEX_SEC_A || second == lcc_pkg::AMEX_SEC_B)) begin
      cls_d = lcc_pkg::VERDICT_AMEX;
    end else if (lead == lcc_pkg::MC_LEAD && second >= lcc_pkg::MC_SEC_LO &&
                 second <= lcc_pkg::MC_SEC_HI) begin
      cls_d = lcc_pkg::VERDICT_MASTERCARD;
    end else if (lead == lcc_pkg::VISA_LEAD) begin
      cls_d = lcc_pkg::VERDICT_VISA;
    end else begin
      cls_d = lcc_pkg::VERDICT_INVALID;
    end
  end

  // Final sum, checksum test and verdict.
  always_comb begin
    total = '0;
    for (int g = 0; g < lcc_pkg::NUM_GROUPS; g++) begin
      total = total + lcc_pkg::SUM_W'(gsum_q[g]);
    end
    if (lcc_pkg::mod10(total) == '0 && long_ok_q) begin
      verdict_d = cls_q;
    end else begin
      verdict_d = lcc_pkg::VERDICT_INVALID;
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gsum_q    <= gsum_d;
      long_ok_q <= long_ok_d;
      cls_q     <= cls_d;
      verdict_q <= verdict_d;
    end
  end

  assign valid_o   = s2_valid_q;
  assign verdict_o = verdict_q;

  // The conversion pipeline must only deliver proper decimal digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> digits_ok)
    else $error("non-decimal digit reached the checksum stage");

  // A number that fails the length test never gets an issuer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && s1_valid_q && !long_ok_q |=> verdict_o == lcc_pkg::VERDICT_INVALID)
    else $error("short number classified as a card");

  // An item in the first stage moves to the output when the pipe advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && s1_valid_q |=> valid_o)
    else $error("item lost between judge stages");

endmodule

`default_nettype wire
